// ===== hdl/optt_pkg.sv =====
`default_nettype none
package optt_pkg;

    typedef enum logic [1:0] {
        CMD_SUBMIT  = 2'd0,
        CMD_REPLY   = 2'd1,
        CMD_COLLECT = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    localparam int unsigned SEQ_BITS   = 16;
    localparam int unsigned REPLY_BITS = 8;
    localparam int unsigned CNT_BITS   = 5;
    localparam int unsigned MISS_BITS  = 32;
    localparam int unsigned TMO_BITS   = 32;
    localparam logic [TMO_BITS-1:0] TMO_RESET = 32'd1000;

endpackage
`default_nettype wire

// ===== hdl/optt_if.sv =====
`default_nettype none
interface optt_cmd_if #(
    parameter int unsigned TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [15:0]          sequence_req;
    logic [TIME_BITS-1:0] event_time;
    modport source (output valid, command, sequence_req, event_time, input ready);
    modport sink   (input valid, command, sequence_req, event_time, output ready);
endinterface

interface optt_res_if #(
    parameter int unsigned TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [TIME_BITS-1:0] sent_time;
    logic [7:0]           reply_count;
    logic [4:0]           expired_count;
    logic [31:0]          missed_run;
    logic [4:0]           occupancy;
    modport source (output valid, status, sent_time, reply_count, expired_count,
                    missed_run, occupancy, input ready);
    modport sink   (input valid, status, sent_time, reply_count, expired_count,
                    missed_run, occupancy, output ready);
endinterface

interface optt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/optt_ram.sv =====
`default_nettype none
module optt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/optt_front.sv =====
`default_nettype none
// front: takes command transfers into a two-entry queue
module optt_front #(
    parameter int unsigned TIME_BITS = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    optt_cmd_if.sink         cmd,
    output logic             o_q_valid,
    output optt_pkg::t_cmd   o_q_cmd,
    output logic [15:0]      o_q_seq,
    output logic [TIME_BITS-1:0] o_q_time,
    input  wire logic        i_q_pop
);
    typedef struct packed {
        optt_pkg::t_cmd       cmd;
        logic [15:0]          seq;
        logic [TIME_BITS-1:0] tm;
    } t_item;

    t_item      r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign cmd.ready = (r_cnt != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_buf[r_rp].cmd;
    assign o_q_seq   = r_buf[r_rp].seq;
    assign o_q_time  = r_buf[r_rp].tm;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= '{optt_pkg::t_cmd'(cmd.command), cmd.sequence_req,
                             cmd.event_time};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/optt_back.sv =====
`default_nettype none
// back: executes one command at a time against the ring store
module optt_back #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_BITS   = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [31:0]          i_timeout,
    input  wire logic                 i_q_valid,
    input  wire optt_pkg::t_cmd       i_q_cmd,
    input  wire logic [15:0]          i_q_seq,
    input  wire logic [TIME_BITS-1:0] i_q_time,
    output logic                      o_q_pop,
    optt_res_if.source                res
);
    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
    localparam int unsigned MW = 16 + TIME_BITS + 8;
    localparam int unsigned EW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_WB   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_idx;
    logic [31:0]          r_miss;
    logic [4:0]           r_exp;
    logic [AW-1:0]        r_slot;

    logic                 we;
    logic [AW-1:0]        waddr, raddr, tail;
    logic [MW-1:0]        wdata, rdata;
    logic [15:0]          rd_seq;
    logic [TIME_BITS-1:0] rd_time;
    logic [7:0]           rd_reply, inc_reply;
    logic                 expired;
    logic [TIME_BITS:0]   diff;

    // result register
    logic                 r_rvalid;
    logic [1:0]           r_status;
    logic [TIME_BITS-1:0] r_sent;
    logic [7:0]           r_rcnt;

    optt_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] t;
        t = v - (AW+1)'(QUEUE_DEPTH);
        return (v >= (AW+1)'(QUEUE_DEPTH)) ? t[AW-1:0] : v[AW-1:0];
    endfunction

    assign rd_seq    = rdata[MW-1 -: 16];
    assign rd_time   = rdata[8 +: TIME_BITS];
    assign rd_reply  = rdata[7:0];
    assign inc_reply = (rd_reply == 8'hFF) ? rd_reply : rd_reply + 8'd1;
    assign diff      = {1'b0, i_q_time} - {1'b0, rd_time};
    assign expired   = !diff[TIME_BITS] &&
                       (EW'(diff[TIME_BITS-1:0]) >= EW'(i_timeout));

    assign raddr = wrap({1'b0, r_head} + (AW+1)'(r_idx));
    assign tail  = wrap({1'b0, r_head} + (AW+1)'(r_count));
    assign we    = ((r_state == S_IDLE) && i_q_valid && !r_rvalid &&
                    (i_q_cmd == optt_pkg::CMD_SUBMIT) && (r_count != FULL)) ||
                   (r_state == S_WB);
    assign waddr = (r_state == S_WB) ? r_slot : tail;
    assign wdata = (r_state == S_WB) ? {rd_seq, rd_time, inc_reply}
                                     : {i_q_seq, i_q_time, 8'd0};
    assign o_q_pop = (r_state == S_OUT);

    assign res.valid         = r_rvalid;
    assign res.status        = r_status;
    assign res.sent_time     = r_sent;
    assign res.reply_count   = r_rcnt;
    assign res.expired_count = r_exp;
    assign res.missed_run    = r_miss;
    assign res.occupancy     = 5'(r_count);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_miss   <= '0;
            r_rvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (res.ready) begin
                r_rvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !r_rvalid) begin
                        r_status <= optt_pkg::ST_OK;
                        r_sent   <= '0;
                        r_rcnt   <= '0;
                        r_exp    <= '0;
                        r_idx    <= '0;
                        unique case (i_q_cmd)
                            optt_pkg::CMD_SUBMIT: begin
                                // new entry is written at the tail slot, after the last entry
                                if (r_count == FULL) begin
                                    r_status <= optt_pkg::ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_count  <= r_count + 1'b1;
                                    r_state  <= S_OUT;
                                end
                            end
                            optt_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_head  <= '0;
                                r_state <= S_OUT;
                            end
                            optt_pkg::CMD_REPLY: begin
                                r_status <= optt_pkg::ST_NOT_FOUND;
                                r_state  <= (r_count == '0) ? S_OUT : S_READ;
                            end
                            optt_pkg::CMD_COLLECT: begin
                                r_state <= (r_count == '0) ? S_OUT : S_READ;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_READ: begin
                    r_slot  <= raddr;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (i_q_cmd == optt_pkg::CMD_REPLY) begin
                        if (rd_seq == i_q_seq) begin
                            r_status <= optt_pkg::ST_OK;
                            r_sent   <= rd_time;
                            r_rcnt   <= inc_reply;
                            r_state  <= S_WB;
                        end else if (r_idx + 1'b1 == r_count) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (expired) begin
                            if (rd_reply == 8'd0) begin
                                if (r_miss != '1) begin
                                    r_miss <= r_miss + 32'd1;
                                end
                            end else begin
                                r_miss <= '0;
                            end
                            r_head  <= wrap({1'b0, r_head} + (AW+1)'(1));
                            r_count <= r_count - 1'b1;
                            r_exp   <= r_exp + 5'd1;
                            r_state <= (r_count == CW'(1)) ? S_OUT : S_READ;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rvalid <= 1'b1;
                    r_idx    <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/outstanding_ping_timeout_tracker.sv =====
`default_nettype none
// channel   | dir | signals
// cmd       | in  | valid, ready, command, sequence_req, event_time
// res       | out | valid, ready, status, sent_time, reply_count, ...
// cfg       | in  | valid, ready, data (timeout_ticks)
//
// for submit, clear and an empty queue the back goes straight to its out state;
// reply lookup and collect visit entries in turn (one ram read and one compare
// per entry), plus a write-back on a match.
// the back starts the next command once the result is taken.
// reset is synchronous; the store has no clearing pass, only the count and head are reset.
// the front queue holds two commands while the back works or its result waits.
module outstanding_ping_timeout_tracker #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_BITS   = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    optt_cmd_if.sink  cmd,
    optt_res_if.source res,
    optt_cfg_if.sink  cfg
);
    logic                 q_valid, q_pop;
    optt_pkg::t_cmd       q_cmd;
    logic [15:0]          q_seq;
    logic [TIME_BITS-1:0] q_time;
    logic [31:0]          r_timeout;

    // timeout register
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= optt_pkg::TMO_RESET;
        end else if (cfg.valid) begin
            r_timeout <= cfg.data;
        end
    end

    optt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .cmd      (cmd),
        .o_q_valid(q_valid),
        .o_q_cmd  (q_cmd),
        .o_q_seq  (q_seq),
        .o_q_time (q_time),
        .i_q_pop  (q_pop)
    );

    optt_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_timeout(r_timeout),
        .i_q_valid(q_valid),
        .i_q_cmd  (q_cmd),
        .i_q_seq  (q_seq),
        .i_q_time (q_time),
        .o_q_pop  (q_pop),
        .res      (res)
    );
endmodule
`default_nettype wire

// ===== hdl/optt_checker.sv =====
`default_nettype none
module optt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_status,
    input wire logic [7:0] res_reply_count,
    input wire logic [4:0] res_occupancy,
    input wire logic [4:0] res_expired_count
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status))
        else $error("result dropped while stalled");

    // status code never reserved
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_status != optt_pkg::ST_RSVD)
        else $error("reserved status");

    // a match reports no expiries
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_status == optt_pkg::ST_OK && res_reply_count != 8'd0
        |-> res_expired_count == 5'd0)
        else $error("reply with expiries");

    // full only with a nonempty queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_status == optt_pkg::ST_FULL |-> res_occupancy != 5'd0)
        else $error("full with empty queue");
endmodule

bind outstanding_ping_timeout_tracker optt_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_status       (res.status),
    .res_reply_count  (res.reply_count),
    .res_occupancy    (res.occupancy),
    .res_expired_count(res.expired_count)
);
`default_nettype wire

// ===== tb/outstanding_ping_timeout_tracker_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module outstanding_ping_timeout_tracker_tb;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned TBITS = 48;
    localparam int unsigned N_RANDOM = 630;

    // expected result of one command
    typedef struct packed {
        optt_pkg::t_status  status;
        logic [TBITS-1:0]   sent_time;
        logic [7:0]         reply_count;
        logic [4:0]         expired_count;
        logic [31:0]        missed_run;
        logic [4:0]         occupancy;
    } t_result;

    // ping queue predictor and store of pending results
    class ping_scoreboard;
        logic [15:0]      seq_mem [DEPTH];
        logic [TBITS-1:0] sent_mem [DEPTH];
        logic [7:0]       reply_mem [DEPTH];
        int unsigned      head;
        int unsigned      count;
        logic [31:0]      miss_run;
        logic [31:0]      timeout;
        t_result          pending [$];
        int unsigned      mismatches;

        function new();
            head = 0;
            count = 0;
            miss_run = '0;
            timeout = optt_pkg::TMO_RESET;
            mismatches = 0;
        endfunction

        function automatic bit expired_at(int unsigned slot, logic [TBITS-1:0] now);
            if (now < sent_mem[slot]) return 1'b0;
            return (now - sent_mem[slot]) >= {16'd0, timeout};
        endfunction

        // note an accepted command and work out its result
        function void note_command(optt_pkg::t_cmd cmd, logic [15:0] seq,
                                   logic [TBITS-1:0] now);
            t_result r;
            int unsigned slot;
            r = '0;
            r.status = optt_pkg::ST_OK;
            case (cmd)
                optt_pkg::CMD_SUBMIT: begin
                    if (count >= DEPTH) begin
                        r.status = optt_pkg::ST_FULL;
                    end else begin
                        slot = (head + count) % DEPTH;
                        seq_mem[slot] = seq;
                        sent_mem[slot] = now;
                        reply_mem[slot] = '0;
                        count++;
                    end
                end
                optt_pkg::CMD_REPLY: begin
                    r.status = optt_pkg::ST_NOT_FOUND;
                    for (int i = 0; i < count; i++) begin
                        slot = (head + i) % DEPTH;
                        if (seq_mem[slot] == seq) begin
                            if (reply_mem[slot] != 8'hff) reply_mem[slot]++;
                            r.sent_time = sent_mem[slot];
                            r.reply_count = reply_mem[slot];
                            r.status = optt_pkg::ST_OK;
                            break;
                        end
                    end
                end
                optt_pkg::CMD_COLLECT: begin
                    while (count > 0 && expired_at(head, now)) begin
                        if (reply_mem[head] == 0) begin
                            if (miss_run != 32'hffff_ffff) miss_run++;
                        end else begin
                            miss_run = '0;
                        end
                        head = (head + 1) % DEPTH;
                        count--;
                        r.expired_count++;
                    end
                end
                default: begin
                    count = 0;
                    head = 0;
                end
            endcase
            r.missed_run = miss_run;
            r.occupancy = count[4:0];
            pending.push_back(r);
        endfunction

        // compare one transfer with the oldest expectation
        function void check_result(t_result act);
            t_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", act);
                return;
            end
            exp = pending.pop_front();
            if (act !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p actual %p", exp, act);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 48;
    ping_scoreboard sb;

    optt_cmd_if #(.TIME_BITS(TBITS)) cmd ();
    optt_res_if #(.TIME_BITS(TBITS)) res ();
    optt_cfg_if cfg ();

    outstanding_ping_timeout_tracker #(.QUEUE_DEPTH(DEPTH), .TIME_BITS(TBITS)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cmd    (cmd.sink),
        .res    (res.source),
        .cfg    (cfg.sink)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        cmd.valid = 1'b0;
        cmd.command = '0;
        cmd.sequence_req = '0;
        cmd.event_time = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        res.ready = 1'b0;
    end

    // result side: random stalls, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result({optt_pkg::t_status'(res.status), res.sent_time,
                             res.reply_count, res.expired_count, res.missed_run,
                             res.occupancy});
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one command, with random idle cycles before it
    task automatic send_cmd(optt_pkg::t_cmd c, logic [15:0] seq, logic [TBITS-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid <= 1'b1;
        cmd.command <= c;
        cmd.sequence_req <= seq;
        cmd.event_time <= now;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        sb.note_command(c, seq, now);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
    endtask

    // register write while idle
    task automatic write_timeout(logic [31:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        sb.timeout = value;
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one random command; mostly sequences that fill, answer and expire
    logic [TBITS-1:0] clock_now;
    task automatic random_cmd();
        int unsigned pick;
        logic [15:0] seq;
        optt_pkg::t_cmd c;
        pick = $urandom_range(99);
        clock_now = clock_now + $urandom_range(sb.timeout > 400 ? 400 : sb.timeout + 3);
        seq = 16'($urandom_range(15));
        if (pick < 40) c = optt_pkg::CMD_SUBMIT;
        else if (pick < 70) c = optt_pkg::CMD_REPLY;
        else if (pick < 96) c = optt_pkg::CMD_COLLECT;
        else c = optt_pkg::CMD_CLEAR;
        if ($urandom_range(19) == 0) seq = 16'($urandom);
        if ($urandom_range(29) == 0) begin
            send_cmd(c, seq, TBITS'({$urandom, $urandom}));
        end else begin
            send_cmd(c, seq, clock_now);
        end
    endtask

    initial begin
        sb = new();
        clock_now = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill to full, overflow, replies, expiry, clear
        send_cmd(optt_pkg::CMD_COLLECT, 16'd0, '0);
        send_cmd(optt_pkg::CMD_REPLY, 16'hffff, '0);
        for (int i = 0; i < DEPTH; i++)
            send_cmd(optt_pkg::CMD_SUBMIT, (i == 3) ? 16'hffff : i[15:0], 48'd100 + i);
        send_cmd(optt_pkg::CMD_SUBMIT, 16'h5a5a, 48'd200);
        send_cmd(optt_pkg::CMD_REPLY, 16'hffff, 48'd300);
        send_cmd(optt_pkg::CMD_REPLY, 16'h1234, 48'd300);
        send_cmd(optt_pkg::CMD_COLLECT, 16'd0, 48'd1102);
        send_cmd(optt_pkg::CMD_COLLECT, 16'd0, 48'd1105);
        send_cmd(optt_pkg::CMD_COLLECT, 16'd0, 48'd50);
        send_cmd(optt_pkg::CMD_CLEAR, 16'd0, '0);
        // wait for everything before the next phase
        drain();
        write_timeout(32'hffff_ffff);
        send_cmd(optt_pkg::CMD_SUBMIT, 16'h0, '0);
        send_cmd(optt_pkg::CMD_COLLECT, 16'h0, 48'hffff_ffff_ffff);
        send_cmd(optt_pkg::CMD_SUBMIT, 16'h7, 48'hffff_ffff_ffff);
        send_cmd(optt_pkg::CMD_COLLECT, 16'h0, 48'hffff_ffff_fffe);
        send_cmd(optt_pkg::CMD_CLEAR, 16'h0, '0);
        write_timeout(32'd1);
        send_cmd(optt_pkg::CMD_SUBMIT, 16'h9, 48'd10);
        // enough replies to saturate the reply count
        for (int i = 0; i < 260; i++) send_cmd(optt_pkg::CMD_REPLY, 16'h9, 48'd10);
        send_cmd(optt_pkg::CMD_REPLY, 16'h9, 48'd10);
        send_cmd(optt_pkg::CMD_COLLECT, 16'h0, 48'd11);

        // random phases with several timeouts
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 48;
                recv_idle_pct = 31;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_timeout(ph == 5 ? 32'd0 : (ph % 2) ? $urandom_range(2000, 1) : 32'd3);
            for (int n = 0; n < N_RANDOM / 6; n++) random_cmd();
        end
        write_timeout(optt_pkg::TMO_RESET);
        for (int n = 0; n < 20; n++) random_cmd();
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== outstanding_ping_timeout_tracker.f =====
hdl/optt_pkg.sv
hdl/optt_if.sv
hdl/optt_ram.sv
hdl/optt_front.sv
hdl/optt_back.sv
hdl/outstanding_ping_timeout_tracker.sv
hdl/optt_checker.sv
tb/outstanding_ping_timeout_tracker_tb.sv
